>>> rtl/core/azds_pkg.sv
`timescale 1ns / 1ps

package azds_pkg;

   // Result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Width of the count of results one byte may raise
   localparam int PUSH_W = 2;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  name_byte;
      logic [15:0] entry_index;
      logic [15:0] name_length;
      logic        name_done;
      logic [31:0] local_offset;
      logic [1:0]  verdict;
      logic [15:0] entry_count;
      logic        last_of_run;
   } rsp_item_type;

   localparam logic RESULT_NAME    = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   localparam logic [1:0] VERDICT_NO_DATA    = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH   = 2'd1;
   localparam logic [1:0] VERDICT_TRUNCATED  = 2'd2;
   localparam logic [1:0] VERDICT_CONSISTENT = 2'd3;

endpackage

>>> rtl/core/azds_rsp_fifo.sv
`timescale 1ns / 1ps

module azds_rsp_fifo
   import azds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [PUSH_W-1:0] push_cnt,
   input  rsp_item_type      push_item0,
   input  rsp_item_type      push_item1,
   input  logic              pop,
   output logic              out_valid,
   output rsp_item_type      out_item,
   output logic              room_two
);

   rsp_item_type           mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   head_ff, head_in;
   logic [RSP_PTR_W-1:0]   tail_ff, tail_in;
   logic [RSP_PTR_W-1:0]   tail_next;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;

   assign tail_next = tail_ff + RSP_PTR_W'(1);
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[head_ff];
   assign room_two  = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      head_in  = pop ? head_ff + RSP_PTR_W'(1) : head_ff;
      tail_in  = tail_ff + RSP_PTR_W'(push_cnt);
      count_in = count_ff + RSP_CNT_W'(push_cnt) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_cnt != '0) begin
         mem_ff[tail_ff] <= push_item0;
      end
      if (push_cnt == PUSH_W'(2)) begin
         mem_ff[tail_next] <= push_item1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue count beyond depth");

   a_pair_room: assert property (@(posedge clock) disable iff (reset)
      (push_cnt == PUSH_W'(2)) |-> room_two)
      else $error("two results pushed without room");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> out_valid)
      else $error("result queue popped while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      !reset |=> count_ff == $past(count_ff) + RSP_CNT_W'($past(push_cnt))
                            - RSP_CNT_W'($past(pop)))
      else $error("result queue count out of step with transfers");

endmodule

>>> rtl/core/appended_zip_directory_scanner_core.sv
`timescale 1ns / 1ps

// Scans a file for an image end marker (FF D9) and then walks the appended ZIP data,
// emitting each central directory entry's name bytes and, at the end of directory
// record or at end of file, one verdict result. One byte is taken per cycle: all
// parsing is done in the cycle of the transfer and its results go straight into a
// four-entry result queue. req_stall is raised only while that queue holds more than
// two results, so with rsp_stall low the block runs at one byte per clock; the byte
// that carries end_of_file may raise two results (last name byte and verdict). After
// the verdict every further byte is taken and dropped until reset.
module appended_zip_directory_scanner_core
   import azds_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_name_byte,
   output logic [15:0] rsp_entry_index,
   output logic [15:0] rsp_name_length,
   output logic        rsp_name_done,
   output logic [31:0] rsp_local_offset,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_entry_count,
   output logic        rsp_last_of_run
);

   localparam logic [2:0] PH_SEARCH  = 3'd0;
   localparam logic [2:0] PH_SCAN    = 3'd1;
   localparam logic [2:0] PH_CENTRAL = 3'd2;
   localparam logic [2:0] PH_ENDREC  = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   localparam logic [31:0] SIG_CENTRAL = 32'h504B_0102;
   localparam logic [31:0] SIG_END     = 32'h504B_0506;

   localparam logic [7:0]  MARK_FIRST  = 8'd255;
   localparam logic [7:0]  MARK_SECOND = 8'd217;

   localparam logic [16:0] POS_SIG_LAST = 17'd3;
   localparam logic [16:0] POS_NLEN_LO  = 17'd28;
   localparam logic [16:0] POS_NLEN_HI  = 17'd29;
   localparam logic [16:0] POS_LOFF_0   = 17'd42;
   localparam logic [16:0] POS_LOFF_1   = 17'd43;
   localparam logic [16:0] POS_LOFF_2   = 17'd44;
   localparam logic [16:0] POS_LOFF_3   = 17'd45;
   localparam logic [16:0] POS_NAME     = 17'd46;
   localparam logic [16:0] POS_CNT_LO   = 17'd10;
   localparam logic [16:0] POS_CNT_HI   = 17'd11;
   localparam logic [16:0] POS_EREC_END = 17'd21;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  prev_ff, prev_in;
   logic [31:0] window_ff, window_in;
   logic [16:0] pos_ff, pos_in;
   logic [15:0] nlen_ff, nlen_in;
   logic [31:0] loff_ff, loff_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] erec_ff, erec_in;
   logic        seen_ff, seen_in;

   logic              accept;
   logic              room_two;
   logic              fire_name;
   logic              fire_verd;
   logic              name_last;
   logic [1:0]        verd_val;
   logic [16:0]       pos_step;
   rsp_item_type      name_item;
   rsp_item_type      verd_item;
   rsp_item_type      push_item0;
   logic [PUSH_W-1:0] push_cnt;
   logic              pop;
   rsp_item_type      head_item;

   assign req_stall = !room_two;
   assign accept    = req_valid && !req_stall;
   assign pos_step  = pos_ff + 17'd1;

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      window_in = window_ff;
      pos_in    = pos_ff;
      nlen_in   = nlen_ff;
      loff_in   = loff_ff;
      count_in  = count_ff;
      erec_in   = erec_ff;
      seen_in   = seen_ff;
      fire_name = 1'b0;
      fire_verd = 1'b0;
      name_last = 1'b0;
      verd_val  = VERDICT_NO_DATA;

      if (accept && phase_ff != PH_DONE) begin
         prev_in = req_data_byte;
         if (phase_ff == PH_SEARCH) begin
            if (prev_ff == MARK_FIRST && req_data_byte == MARK_SECOND) begin
               phase_in  = PH_SCAN;
               window_in = '0;
            end
         end else begin
            seen_in   = 1'b1;
            window_in = {window_ff[23:0], req_data_byte};
            if (window_in == SIG_CENTRAL) begin
               // restart the capture even if one was under way
               phase_in = PH_CENTRAL;
               pos_in   = POS_SIG_LAST;
               nlen_in  = '0;
               loff_in  = '0;
               if (count_ff != 16'hFFFF) begin
                  count_in = count_ff + 16'd1;
               end
            end else if (window_in == SIG_END) begin
               phase_in = PH_ENDREC;
               pos_in   = POS_SIG_LAST;
               erec_in  = '0;
            end else if (phase_ff == PH_CENTRAL) begin
               pos_in = pos_step;
               case (pos_step)
                  POS_NLEN_LO: nlen_in = {8'h00, req_data_byte};
                  POS_NLEN_HI: nlen_in = {req_data_byte, nlen_ff[7:0]};
                  POS_LOFF_0:  loff_in[7:0]   = req_data_byte;
                  POS_LOFF_1:  loff_in[15:8]  = req_data_byte;
                  POS_LOFF_2:  loff_in[23:16] = req_data_byte;
                  POS_LOFF_3: begin
                     loff_in[31:24] = req_data_byte;
                     if (nlen_ff == '0) begin
                        phase_in = PH_SCAN;
                     end
                  end
                  default: begin
                     if (pos_step >= POS_NAME) begin
                        fire_name = 1'b1;
                        name_last = (pos_step >= ({1'b0, nlen_ff} + POS_LOFF_3));
                        if (name_last) begin
                           phase_in = PH_SCAN;
                        end
                     end
                  end
               endcase
            end else if (phase_ff == PH_ENDREC) begin
               pos_in = pos_step;
               if (pos_step == POS_CNT_LO) begin
                  erec_in = {8'h00, req_data_byte};
               end else if (pos_step == POS_CNT_HI) begin
                  erec_in = {req_data_byte, erec_ff[7:0]};
               end else if (pos_step >= POS_EREC_END) begin
                  fire_verd = 1'b1;
                  verd_val  = (erec_ff != '0 && erec_ff == count_ff) ?
                              VERDICT_CONSISTENT : VERDICT_MISMATCH;
                  phase_in  = PH_DONE;
               end
            end
         end

         // early end of file: verdict follows any name byte of this transfer
         if (req_end_of_file && !fire_verd) begin
            fire_verd = 1'b1;
            if (phase_in == PH_SEARCH || !seen_in) begin
               verd_val = VERDICT_NO_DATA;
            end else if (phase_in == PH_ENDREC) begin
               verd_val = VERDICT_TRUNCATED;
            end else begin
               verd_val = VERDICT_MISMATCH;
            end
            phase_in = PH_DONE;
         end
      end
   end

   always_comb begin
      name_item              = '0;
      name_item.result_kind  = RESULT_NAME;
      name_item.name_byte    = req_data_byte;
      name_item.entry_index  = count_ff - 16'd1;
      name_item.name_length  = nlen_ff;
      name_item.name_done    = name_last;
      name_item.local_offset = loff_ff;
      name_item.entry_count  = count_in;
      name_item.last_of_run  = !fire_verd;

      verd_item              = '0;
      verd_item.result_kind  = RESULT_VERDICT;
      verd_item.verdict      = verd_val;
      verd_item.entry_count  = count_in;
      verd_item.last_of_run  = 1'b1;

      push_item0 = fire_name ? name_item : verd_item;
      push_cnt   = PUSH_W'(fire_name) + PUSH_W'(fire_verd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEARCH;
         prev_ff   <= '0;
         window_ff <= '0;
         pos_ff    <= '0;
         nlen_ff   <= '0;
         loff_ff   <= '0;
         count_ff  <= '0;
         erec_ff   <= '0;
         seen_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         prev_ff   <= prev_in;
         window_ff <= window_in;
         pos_ff    <= pos_in;
         nlen_ff   <= nlen_in;
         loff_ff   <= loff_in;
         count_ff  <= count_in;
         erec_ff   <= erec_in;
         seen_ff   <= seen_in;
      end
   end

   assign pop = rsp_valid && !rsp_stall;

   azds_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_cnt   (push_cnt),
      .push_item0 (push_item0),
      .push_item1 (verd_item),
      .pop        (pop),
      .out_valid  (rsp_valid),
      .out_item   (head_item),
      .room_two   (room_two)
   );

   assign rsp_result_kind  = head_item.result_kind;
   assign rsp_name_byte    = head_item.name_byte;
   assign rsp_entry_index  = head_item.entry_index;
   assign rsp_name_length  = head_item.name_length;
   assign rsp_name_done    = head_item.name_done;
   assign rsp_local_offset = head_item.local_offset;
   assign rsp_verdict      = head_item.verdict;
   assign rsp_entry_count  = head_item.entry_count;
   assign rsp_last_of_run  = head_item.last_of_run;

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> (push_cnt == '0))
      else $error("result raised after the verdict");

   a_verdict_ends: assert property (@(posedge clock) disable iff (reset)
      fire_verd |=> (phase_ff == PH_DONE))
      else $error("verdict given without closing the scan");

   a_name_in_central: assert property (@(posedge clock) disable iff (reset)
      fire_name |-> (phase_ff == PH_CENTRAL && count_ff != '0))
      else $error("name byte outside a central header");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import azds_pkg::*;

   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_BYTES  = 1200;
   localparam int MODE_SWAP_AT  = 600;
   localparam int MODE_QUIET_AT = 1200;
   localparam int HOLD_AT       = 1300;
   localparam int HOLD_LENGTH   = 150;
   localparam int WHOLE         = 1 << 20;
   localparam int MAX_PRINTED   = 50;

   localparam logic [7:0]  MARK_FF     = 8'hFF;
   localparam logic [7:0]  MARK_D9     = 8'hD9;
   localparam logic [7:0]  ASCII_P     = 8'h50;
   localparam logic [7:0]  ASCII_K     = 8'h4B;
   localparam logic [31:0] SIG_CENTRAL = 32'h504B0102;
   localparam logic [31:0] SIG_END     = 32'h504B0506;
   localparam logic [31:0] SIG_LOCAL   = 32'h504B0304;

   // positions within a record, counted from the first signature byte
   localparam int NAME_LEN_POS    = 28;
   localparam int OFFSET_POS      = 42;
   localparam int NAME_POS        = 46;
   localparam int DIR_COUNT_POS   = 10;
   localparam int END_RECORD_LAST = 21;

   typedef enum logic [2:0] {
      SEEK_IMAGE_END,
      SCAN_ZIP,
      IN_CENTRAL,
      IN_END_RECORD,
      ARCHIVE_DONE
   } scan_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eof;
   } file_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_file = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_result_kind;
   logic [7:0]  rsp_name_byte;
   logic [15:0] rsp_entry_index;
   logic [15:0] rsp_name_length;
   logic        rsp_name_done;
   logic [31:0] rsp_local_offset;
   logic [1:0]  rsp_verdict;
   logic [15:0] rsp_entry_count;
   logic        rsp_last_of_run;

   appended_zip_directory_scanner_core uut (.*);

   always #1 clock = ~clock;

   file_byte_type file_bytes[$];
   rsp_item_type  directory_results[$];

   int   reset_count = 0;
   int   bytes_taken = 0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   hold_cycles = 0;
   logic hold_done = 1'b0;
   logic req_taken = 1'b0;

   // scanner state as the block should hold it
   scan_phase_type scan_phase = SEEK_IMAGE_END;
   logic [7:0]     prior_byte = 8'h00;
   logic [31:0]    sig_window = 32'h0;
   logic [16:0]    record_pos = 17'h0;
   logic [15:0]    name_len_cap = 16'h0;
   logic [31:0]    local_off_cap = 32'h0;
   logic [15:0]    entries_seen = 16'h0;
   logic [15:0]    dir_total = 16'h0;
   logic           zip_seen = 1'b0;

   function automatic rsp_item_type verdict_result(input logic [1:0] v);
      rsp_item_type r;
      r = '0;
      r.result_kind = RESULT_VERDICT;
      r.verdict = v;
      r.entry_count = entries_seen;
      return r;
   endfunction

   task automatic walk_directory_byte(input logic [7:0] b, input logic eof);
      rsp_item_type r;
      logic [16:0]  p;
      logic [31:0]  k;
      logic [1:0]   v;
      logic         have_r;
      r = '0;
      have_r = 1'b0;
      if (scan_phase == ARCHIVE_DONE) return;
      if (scan_phase == SEEK_IMAGE_END) begin
         if (prior_byte == MARK_FF && b == MARK_D9) begin
            scan_phase = SCAN_ZIP;
            sig_window = '0;
         end
      end else begin
         zip_seen = 1'b1;
         sig_window = {sig_window[23:0], b};
         if (sig_window == SIG_CENTRAL) begin
            scan_phase = IN_CENTRAL;
            record_pos = 17'd3;
            name_len_cap = '0;
            local_off_cap = '0;
            if (entries_seen != 16'hFFFF) entries_seen = entries_seen + 16'd1;
         end else if (sig_window == SIG_END) begin
            scan_phase = IN_END_RECORD;
            record_pos = 17'd3;
            dir_total = '0;
         end else if (scan_phase == IN_CENTRAL) begin
            p = record_pos + 17'd1;
            record_pos = p;
            if (p == NAME_LEN_POS) begin
               name_len_cap = {8'h00, b};
            end else if (p == NAME_LEN_POS + 1) begin
               name_len_cap[15:8] = b;
            end else if (p >= OFFSET_POS && p < NAME_POS) begin
               local_off_cap = local_off_cap | ({24'h0, b} << (8 * (p - OFFSET_POS)));
               if (p == NAME_POS - 1 && name_len_cap == 16'd0) scan_phase = SCAN_ZIP;
            end else if (p >= NAME_POS) begin
               k = p - NAME_POS;
               r.result_kind = RESULT_NAME;
               r.name_byte = b;
               r.entry_index = entries_seen - 16'd1;
               r.name_length = name_len_cap;
               r.name_done = (k + 1 >= name_len_cap);
               r.local_offset = local_off_cap;
               r.entry_count = entries_seen;
               have_r = 1'b1;
               if (r.name_done) scan_phase = SCAN_ZIP;
            end
         end else if (scan_phase == IN_END_RECORD) begin
            p = record_pos + 17'd1;
            record_pos = p;
            if (p == DIR_COUNT_POS) begin
               dir_total = {8'h00, b};
            end else if (p == DIR_COUNT_POS + 1) begin
               dir_total[15:8] = b;
            end else if (p >= END_RECORD_LAST) begin
               r = verdict_result((dir_total != 0 && dir_total == entries_seen) ?
                                  VERDICT_CONSISTENT : VERDICT_MISMATCH);
               have_r = 1'b1;
               scan_phase = ARCHIVE_DONE;
            end
         end
      end
      prior_byte = b;
      // early end of file: verdict follows any name byte of this transfer
      if (eof && scan_phase != ARCHIVE_DONE) begin
         if (have_r) directory_results.push_back(r);
         if (scan_phase == SEEK_IMAGE_END || !zip_seen) v = VERDICT_NO_DATA;
         else if (scan_phase == IN_END_RECORD) v = VERDICT_TRUNCATED;
         else v = VERDICT_MISMATCH;
         r = verdict_result(v);
         have_r = 1'b1;
         scan_phase = ARCHIVE_DONE;
      end
      if (have_r) begin
         r.last_of_run = 1'b1;
         directory_results.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_PRINTED)
         $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_result(input rsp_item_type seen);
      rsp_item_type due;
      if (directory_results.size() == 0) begin
         report_mismatch("result with none due", 32'(seen.result_kind), 32'd0);
         return;
      end
      due = directory_results.pop_front();
      if (seen.result_kind !== due.result_kind)
         report_mismatch("result_kind", 32'(seen.result_kind), 32'(due.result_kind));
      if (seen.name_byte !== due.name_byte)
         report_mismatch("name_byte", 32'(seen.name_byte), 32'(due.name_byte));
      if (seen.entry_index !== due.entry_index)
         report_mismatch("entry_index", 32'(seen.entry_index), 32'(due.entry_index));
      if (seen.name_length !== due.name_length)
         report_mismatch("name_length", 32'(seen.name_length), 32'(due.name_length));
      if (seen.name_done !== due.name_done)
         report_mismatch("name_done", 32'(seen.name_done), 32'(due.name_done));
      if (seen.local_offset !== due.local_offset)
         report_mismatch("local_offset", seen.local_offset, due.local_offset);
      if (seen.verdict !== due.verdict)
         report_mismatch("verdict", 32'(seen.verdict), 32'(due.verdict));
      if (seen.entry_count !== due.entry_count)
         report_mismatch("entry_count", 32'(seen.entry_count), 32'(due.entry_count));
      if (seen.last_of_run !== due.last_of_run)
         report_mismatch("last_of_run", 32'(seen.last_of_run), 32'(due.last_of_run));
   endtask

   function automatic logic sender_idles();
      if (bytes_taken < MODE_SWAP_AT) return $urandom_range(0, 99) < 29;
      if (bytes_taken < MODE_QUIET_AT) return $urandom_range(0, 99) < 53;
      return 1'b0;
   endfunction

   function automatic logic receiver_idles();
      if (bytes_taken < MODE_SWAP_AT) return $urandom_range(0, 99) < 53;
      if (bytes_taken < MODE_QUIET_AT) return $urandom_range(0, 99) < 29;
      return 1'b0;
   endfunction

   // stimulus builders
   task automatic put_byte(input logic [7:0] b, input logic eof);
      file_byte_type fb;
      fb.data = b;
      fb.eof = eof;
      file_bytes.push_back(fb);
   endtask

   task automatic put_signature(input logic [31:0] sig);
      put_byte(sig[31:24], 1'b0);
      put_byte(sig[23:16], 1'b0);
      put_byte(sig[15:8], 1'b0);
      put_byte(sig[7:0], 1'b0);
   endtask

   task automatic put_noise(input int n);
      int i;
      int pick;
      for (i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 25) put_byte(ASCII_P, 1'b0);
         else if (pick < 40) put_byte(ASCII_K, 1'b0);
         else put_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // central header cut after keep bytes (keep >= 4), eof on the last byte sent
   task automatic put_central(input logic [15:0] nlen, input logic [31:0] loff,
                              input int keep, input logic eof_last);
      int total;
      int i;
      logic [7:0] b;
      total = NAME_POS + nlen;
      if (keep < total) total = keep;
      put_signature(SIG_CENTRAL);
      for (i = 4; i < total; i++) begin
         if (i == NAME_LEN_POS) b = nlen[7:0];
         else if (i == NAME_LEN_POS + 1) b = nlen[15:8];
         else if (i >= OFFSET_POS && i < NAME_POS) b = 8'(loff >> (8 * (i - OFFSET_POS)));
         else b = 8'($urandom_range(0, 255));
         put_byte(b, eof_last && i == total - 1);
      end
   endtask

   task automatic put_end_record(input logic [15:0] count, input int keep,
                                 input logic eof_last);
      int total;
      int i;
      logic [7:0] b;
      total = END_RECORD_LAST + 1;
      if (keep < total) total = keep;
      put_signature(SIG_END);
      for (i = 4; i < total; i++) begin
         if (i == DIR_COUNT_POS) b = count[7:0];
         else if (i == DIR_COUNT_POS + 1) b = count[15:8];
         else b = 8'($urandom_range(0, 255));
         put_byte(b, eof_last && i == total - 1);
      end
   endtask

   function automatic logic [15:0] short_name_length();
      if ($urandom_range(0, 99) < 90) return 16'($urandom_range(0, 12));
      return 16'($urandom_range(13, 60));
   endfunction

   // driver: new transfer only once the previous one was taken
   always @(negedge clock) begin : driver
      file_byte_type fb;
      if (reset_count < RESET_CYCLES) begin
         reset_count <= reset_count + 1;
      end else begin
         reset <= 1'b0;
         if (!req_valid || req_taken) begin
            if (file_bytes.size() != 0 && !sender_idles()) begin
               fb = file_bytes.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= fb.data;
               req_end_of_file <= fb.eof;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (hold_cycles != 0) || receiver_idles();
      end
   end

   // monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin : monitor
      rsp_item_type seen;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            walk_directory_byte(req_data_byte, req_end_of_file);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_result_kind, rsp_name_byte, rsp_entry_index, rsp_name_length,
                    rsp_name_done, rsp_local_offset, rsp_verdict, rsp_entry_count,
                    rsp_last_of_run};
            check_result(seen);
         end
      end
   end

   // long receiver hold-off so the result queue fills and the input backs up
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end else if (!hold_done && bytes_taken >= HOLD_AT && rsp_valid) begin
         hold_cycles <= HOLD_LENGTH;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin : stimulus
      int random_end;
      int pick;
      int ending;
      logic [15:0] wrong_count;

      // before the marker: stray FF, signature bytes that must not count, lone D9
      put_byte(8'h00, 1'b0);
      put_byte(MARK_FF, 1'b0);
      put_byte(8'h00, 1'b0);
      put_byte(ASCII_P, 1'b0);
      put_byte(ASCII_K, 1'b0);
      put_byte(8'h01, 1'b0);
      put_byte(MARK_D9, 1'b0);
      put_byte(MARK_FF, 1'b0);
      put_byte(MARK_FF, 1'b0);
      put_byte(MARK_D9, 1'b0);
      // would complete a signature if the window leaked across the marker
      put_byte(8'h02, 1'b0);
      put_central(16'd0, 32'hFFFF_FFFF, WHOLE, 1'b0);
      put_central(16'd1, 32'h0, WHOLE, 1'b0);
      // huge name cut short by the next signature
      put_central(16'hFFFF, 32'h8000_0001, NAME_POS + 3, 1'b0);
      // restart before the name length is captured
      put_central(16'd5, $urandom, 20, 1'b0);
      put_central(16'd3, $urandom, WHOLE, 1'b0);
      put_end_record(16'd7, 9, 1'b0);
      put_central(16'd2, $urandom, WHOLE, 1'b0);

      random_end = file_bytes.size() + RANDOM_BYTES;
      while (file_bytes.size() < random_end) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            put_central(short_name_length(), $urandom, WHOLE, 1'b0);
            put_noise($urandom_range(0, 3));
         end else if (pick < 70) begin
            put_signature(SIG_LOCAL);
            put_noise($urandom_range(0, 30));
         end else if (pick < 80) begin
            put_central(short_name_length(), $urandom, $urandom_range(4, 60), 1'b0);
         end else if (pick < 90) begin
            put_noise($urandom_range(1, 8));
         end else begin
            // broken end record; a central header must follow to leave it
            put_end_record(16'($urandom), $urandom_range(4, 20), 1'b0);
            put_central(short_name_length(), $urandom, WHOLE, 1'b0);
         end
      end

      // name one more entry before the pause
      put_central(16'd4, $urandom, WHOLE, 1'b0);
      put_noise(4);

      // hold until everything sent so far has been answered
      while (file_bytes.size() != 0 || req_valid || directory_results.size() != 0)
         @(posedge clock);

      ending = $urandom_range(0, 7);
      case (ending)
         0, 1, 2: put_end_record(entries_seen, WHOLE, 1'($urandom_range(0, 1)));
         3: begin
            wrong_count = 16'($urandom_range(1, 65535));
            put_end_record(entries_seen ^ wrong_count, WHOLE, 1'b0);
         end
         4: put_end_record(16'd0, WHOLE, 1'b0);
         5: put_end_record(entries_seen, $urandom_range(4, END_RECORD_LAST), 1'b1);
         6: put_central(16'd3, $urandom, NAME_POS + $urandom_range(1, 3), 1'b1);
         default: begin
            put_noise(5);
            put_byte(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
      // dropped after the verdict
      repeat (12) put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      while (file_bytes.size() != 0 || req_valid || directory_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> appended_zip_directory_scanner_core.f
rtl/core/azds_pkg.sv
rtl/core/azds_rsp_fifo.sv
rtl/core/appended_zip_directory_scanner_core.sv
test/tb_top.sv
